FILE: sv/fresnel_unpolarized_coefficients_core_macros.svh
// Assertion macros shared by the Fresnel coefficient core.
`ifndef FRESNEL_UNPOLARIZED_COEFFICIENTS_CORE_MACROS_SVH
`define FRESNEL_UNPOLARIZED_COEFFICIENTS_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, disabled during reset.
`define FUPC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fupc assertion failed");

// Next-cycle implication, sampled on clk_i, disabled during reset.
`define FUPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fupc assertion failed");

`endif

FILE: sv/fupc_pkg.sv
// Types and constants of the Fresnel coefficient core.
`default_nettype none
package fupc_pkg;

  localparam int CompW     = 16;
  localparam int IdxW      = 16;
  localparam int OutW      = 16;
  localparam int CosW      = 2 * CompW + 2;
  localparam int ProdW     = CosW + IdxW + 1;
  localparam int SumW      = ProdW + 1;
  localparam int RemW      = SumW + 1;
  localparam int RatioFrac = 30;
  localparam int SqW       = 2 * RatioFrac + 1;
  localparam int AccW      = SqW + 1;
  localparam int RoundPos  = 2 * RatioFrac - 16;
  localparam int OutShift  = 2 * RatioFrac - 14;
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  localparam logic [OutW-1:0] UnitQ15 = OutW'(32768);

  localparam longint TirSqNum = 64'd152399025;
  localparam longint TirSqDen = 64'd9765625;
  localparam longint TirLimit = (TirSqNum << (2 * (CompW - 2) - 10)) / TirSqDen;

  typedef struct packed {
    logic signed [CompW-1:0] normal_x;
    logic signed [CompW-1:0] normal_y;
    logic signed [CompW-1:0] normal_z;
    logic signed [CompW-1:0] incident_x;
    logic signed [CompW-1:0] incident_y;
    logic signed [CompW-1:0] incident_z;
    logic signed [CompW-1:0] transmit_x;
    logic signed [CompW-1:0] transmit_y;
    logic signed [CompW-1:0] transmit_z;
    logic [IdxW-1:0]         index_incident;
    logic [IdxW-1:0]         index_transmitted;
  } fupc_in_t;

  typedef struct packed {
    logic [OutW-1:0] reflectance;
    logic [OutW-1:0] transmittance;
    logic            total_internal;
  } fupc_out_t;

  typedef struct packed {
    logic                   total_internal;
    logic signed [CosW-1:0] cos_i;
    logic signed [CosW-1:0] cos_t;
    logic [IdxW-1:0]        index_incident;
    logic [IdxW-1:0]        index_transmitted;
  } fupc_item_t;

endpackage
`default_nettype wire

FILE: sv/fresnel_unpolarized_coefficients_core.sv
// Top level of the unpolarized Fresnel reflectance and transmittance core.
//
// One input transaction carries a surface normal, an incident and a transmitted
// direction in signed Q2.14 and two refractive indices in unsigned Q3.13. Each
// one yields exactly one output transaction with reflectance and transmittance
// in Q1.15 and a total internal reflection flag. Both channels use valid and
// ready.
// The front end takes one transaction per cycle while the queue has room and
// registers the component products, then the dot products and the reflection
// test; a four-entry queue follows. The back end is a 36-stage pipeline whose
// 30 stages each resolve one quotient bit of the two Fresnel ratios, and one
// result leaves per cycle while the receiver holds ready high. There is no state
// between transactions.
// Reset empties all pipelines and the queue. When the receiver holds ready low
// the back end freezes with its result held in the output register, the queue
// fills, and then the front end stops taking input.
`default_nettype none
`include "fresnel_unpolarized_coefficients_core_macros.svh"
module fresnel_unpolarized_coefficients_core import fupc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  fupc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output fupc_out_t out_data_o
);

  logic       fq_valid, fq_ready, bq_valid, bq_ready;
  fupc_item_t fq_item, bq_item;

  fupc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_item_o   (fq_item)
  );

  fupc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_item_i  (fq_item),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_item_o   (bq_item)
  );

  fupc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (bq_valid),
    .q_ready_o   (bq_ready),
    .q_item_i    (bq_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `FUPC_ASSERT_IMPL(a_tir_result, out_valid_o && out_data_o.total_internal,
    out_data_o.reflectance == UnitQ15 && out_data_o.transmittance == '0)
  `FUPC_ASSERT_IMPL(a_sum_unit, out_valid_o,
    (OutW+1)'(out_data_o.reflectance) + (OutW+1)'(out_data_o.transmittance)
      == (OutW+1)'(UnitQ15))

endmodule
`default_nettype wire

FILE: sv/fupc_front.sv
// Front end: dot products, length test and total internal reflection flag.
`default_nettype none
module fupc_front import fupc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  fupc_in_t   in_data_i,
  output logic       q_valid_o,
  input  logic       q_ready_i,
  output fupc_item_t q_item_o
);

  logic                    en;
  logic                    a_vld_q, b_vld_q;
  logic signed [2*CompW-1:0] nt_q [3];
  logic signed [2*CompW-1:0] ni_q [3];
  logic signed [2*CompW-1:0] tt_q [3];
  logic [IdxW-1:0]         idx_i_q, idx_t_q;
  logic signed [CosW-1:0]  dnt, dni, lensq;
  fupc_item_t              item_d, item_q;

  assign en         = !b_vld_q || q_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nt_q[0] <= in_data_i.normal_x * in_data_i.transmit_x;
      nt_q[1] <= in_data_i.normal_y * in_data_i.transmit_y;
      nt_q[2] <= in_data_i.normal_z * in_data_i.transmit_z;
      ni_q[0] <= in_data_i.normal_x * in_data_i.incident_x;
      ni_q[1] <= in_data_i.normal_y * in_data_i.incident_y;
      ni_q[2] <= in_data_i.normal_z * in_data_i.incident_z;
      tt_q[0] <= in_data_i.transmit_x * in_data_i.transmit_x;
      tt_q[1] <= in_data_i.transmit_y * in_data_i.transmit_y;
      tt_q[2] <= in_data_i.transmit_z * in_data_i.transmit_z;
      idx_i_q <= in_data_i.index_incident;
      idx_t_q <= in_data_i.index_transmitted;
      item_q  <= item_d;
    end
  end

  always_comb begin
    dnt   = CosW'(nt_q[0]) + CosW'(nt_q[1]) + CosW'(nt_q[2]);
    dni   = CosW'(ni_q[0]) + CosW'(ni_q[1]) + CosW'(ni_q[2]);
    lensq = CosW'(tt_q[0]) + CosW'(tt_q[1]) + CosW'(tt_q[2]);
    item_d.total_internal    = (lensq <= CosW'(TirLimit)) || (dnt > 0);
    item_d.cos_i             = dni;
    item_d.cos_t             = -dnt;
    item_d.index_incident    = idx_i_q;
    item_d.index_transmitted = idx_t_q;
  end

  assign q_valid_o = b_vld_q;
  assign q_item_o  = item_q;

endmodule
`default_nettype wire

FILE: sv/fupc_fifo.sv
// Short queue between the front end and the back end.
`default_nettype none
`include "fresnel_unpolarized_coefficients_core_macros.svh"
module fupc_fifo import fupc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  fupc_item_t push_item_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output fupc_item_t pop_item_o
);

  fupc_item_t        mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   count_q;
  logic              push, pop;

  assign push_ready_o = count_q != (FifoAw+1)'(FifoDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_item_i;
  end

  `FUPC_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= (FifoAw+1)'(FifoDepth))
  `FUPC_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1)
  `FUPC_ASSERT_IMPL(a_ptr_gap, 1'b1, FifoAw'(wr_ptr_q - rd_ptr_q) == FifoAw'(count_q))

endmodule
`default_nettype wire

FILE: sv/fupc_back.sv
// Back end: Fresnel ratios, bit-per-stage division, squaring and averaging.
`default_nettype none
module fupc_back import fupc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  output logic       q_ready_o,
  input  fupc_item_t q_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output fupc_out_t  out_data_o
);

  logic en;
  logic p_vld_q, s_vld_q, m_vld_q, sq_vld_q, out_vld_q;
  logic p_tir_q, s_tir_q, m_tir_q, sq_tir_q;
  logic signed [ProdW-1:0] a_q [2];
  logic signed [ProdW-1:0] b_q [2];
  logic signed [SumW-1:0]  num_q [2];
  logic signed [SumW-1:0]  den_q [2];
  logic [SumW-1:0]         anum_q [2];
  logic [SumW-1:0]         aden_q [2];
  logic signed [IdxW:0]    ni_s, nt_s;

  logic [RatioFrac:0]  dv_q;
  logic [RatioFrac:0]  dtir_q;
  logic [1:0]          dsat_q [RatioFrac+1];
  logic [SumW-1:0]     rem_q  [RatioFrac+1][2];
  logic [SumW-1:0]     dd_q   [RatioFrac+1][2];
  logic [RatioFrac-1:0] quo_q [RatioFrac+1][2];

  logic [SqW-1:0]  sq_q [2];
  logic [AccW-1:0] acc;
  logic [OutW-1:0] refl;
  fupc_out_t       out_q, out_d;

  assign en          = !out_vld_q || out_ready_i;
  assign q_ready_o   = en;
  assign ni_s        = $signed({1'b0, q_item_i.index_incident});
  assign nt_s        = $signed({1'b0, q_item_i.index_transmitted});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q   <= 1'b0;
      s_vld_q   <= 1'b0;
      m_vld_q   <= 1'b0;
      dv_q      <= '0;
      sq_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q   <= q_valid_i;
      s_vld_q   <= p_vld_q;
      m_vld_q   <= s_vld_q;
      dv_q      <= {dv_q[RatioFrac-1:0], m_vld_q};
      sq_vld_q  <= dv_q[RatioFrac];
      out_vld_q <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_tir_q <= q_item_i.total_internal;
      a_q[0]  <= ni_s * q_item_i.cos_i;
      b_q[0]  <= nt_s * q_item_i.cos_t;
      a_q[1]  <= ni_s * q_item_i.cos_t;
      b_q[1]  <= nt_s * q_item_i.cos_i;
      s_tir_q <= p_tir_q;
      m_tir_q <= s_tir_q;
      for (int r = 0; r < 2; r++) begin
        num_q[r]  <= SumW'(a_q[r]) - SumW'(b_q[r]);
        den_q[r]  <= SumW'(a_q[r]) + SumW'(b_q[r]);
        anum_q[r] <= num_q[r][SumW-1] ? SumW'(-num_q[r]) : SumW'(num_q[r]);
        aden_q[r] <= den_q[r][SumW-1] ? SumW'(-den_q[r]) : SumW'(den_q[r]);
        dsat_q[0][r] <= (aden_q[r] == '0) || (anum_q[r] >= aden_q[r]);
        rem_q[0][r]  <= anum_q[r];
        dd_q[0][r]   <= aden_q[r];
        quo_q[0][r]  <= '0;
      end
      dtir_q[0] <= m_tir_q;
    end
  end

  for (genvar k = 0; k < RatioFrac; k++) begin : g_div
    logic [RemW-1:0] r2 [2];
    logic [1:0]      ge;
    always_comb begin
      for (int r = 0; r < 2; r++) begin
        r2[r] = {rem_q[k][r], 1'b0};
        ge[r] = r2[r] >= {1'b0, dd_q[k][r]};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dtir_q[k+1] <= dtir_q[k];
        dsat_q[k+1] <= dsat_q[k];
        for (int r = 0; r < 2; r++) begin
          rem_q[k+1][r] <= ge[r] ? SumW'(r2[r] - {1'b0, dd_q[k][r]}) : r2[r][SumW-1:0];
          dd_q[k+1][r]  <= dd_q[k][r];
          quo_q[k+1][r] <= {quo_q[k][r][RatioFrac-2:0], ge[r]};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_tir_q <= dtir_q[RatioFrac];
      for (int r = 0; r < 2; r++) begin
        sq_q[r] <= dsat_q[RatioFrac][r] ? (SqW'(1) << (2 * RatioFrac))
                                        : SqW'(quo_q[RatioFrac][r])
                                          * SqW'(quo_q[RatioFrac][r]);
      end
      out_q <= out_d;
    end
  end

  always_comb begin
    acc  = AccW'(sq_q[0]) + AccW'(sq_q[1]) + (AccW'(1) << RoundPos);
    refl = acc[AccW-1:OutShift];
    if (refl > UnitQ15) refl = UnitQ15;
    if (sq_tir_q) begin
      out_d.reflectance    = UnitQ15;
      out_d.transmittance  = '0;
      out_d.total_internal = 1'b1;
    end else begin
      out_d.reflectance    = refl;
      out_d.transmittance  = UnitQ15 - refl;
      out_d.total_internal = 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
